// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// types and constants of the address text classifier
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned VERDICT_W   = 2;

    localparam int unsigned V4_GC_W     = 3;
    localparam int unsigned V4_DC_W     = 2;
    localparam int unsigned V4_VAL_W    = 9;
    localparam int unsigned V4_PROD_W   = 12;
    localparam int unsigned V6_GC_W     = 4;
    localparam int unsigned V6_DC_W     = 3;

    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_F  = 8'h46;

    localparam logic [V4_GC_W-1:0]   V4_GROUPS_MAX = 3'd3;
    localparam logic [V4_DC_W-1:0]   V4_DIGITS_MAX = 2'd3;
    localparam logic [V4_VAL_W-1:0]  V4_VALUE_MAX  = 9'd255;
    localparam logic [V4_PROD_W-1:0] V4_VALUE_SAT  = 12'd256;
    localparam logic [V4_PROD_W-1:0] V4_RADIX      = 12'd10;
    localparam logic [V6_GC_W-1:0]   V6_GROUPS_MAX = 4'd7;
    localparam logic [V6_DC_W-1:0]   V6_DIGITS_MAX = 3'd4;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_NONE = 2'd0,
        VERDICT_V4   = 2'd1,
        VERDICT_V6   = 2'd2
    } t_verdict;

endpackage

// File: rtl/ipc_if.sv
// ----------------------------------------------------------------------------
// ipc channel interfaces
// valid/ready channels for characters in and verdicts out
// ----------------------------------------------------------------------------
interface ipc_char_if;
    logic                        valid;
    logic                        ready;
    logic [ipc_pkg::CHAR_W-1:0]  character;
    logic                        last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface ipc_verdict_if;
    logic                          valid;
    logic                          ready;
    logic [ipc_pkg::VERDICT_W-1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

// File: rtl/ip_address_text_classifier.sv
// ----------------------------------------------------------------------------
// ip_address_text_classifier
// classifies an address string as ipv4, ipv6 or neither, one character per item
// ----------------------------------------------------------------------------
// usage:
//   i_char carries one ascii character per item, last_char set on the final
//   character of a string. o_verdict carries one item per string: 0 neither,
//   1 valid ipv4, 2 valid ipv6. a dot anywhere in the string selects ipv4.
//   the final character passes the input register, then the state update loads
//   the verdict into the result register. throughput: one character per cycle
//   unless a final character waits; the per-character counter and compare
//   update is a single registered step, so strings stream back to back.
//   a stalled o_verdict holds its item; further characters that are not final
//   keep flowing, and a final character waits in the input register, holding
//   i_char.ready low, until the result register frees.
//   reset (i_rst_n low, synchronous) empties both registers and clears the
//   per-string state; the state clears again after every verdict.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ip_address_text_classifier (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ipc_char_if.sink       i_char,
    ipc_verdict_if.source  o_verdict
);

    logic                                r_in_valid;
    logic [ipc_pkg::CHAR_W-1:0]          r_char;
    logic                                r_last;

    logic                                r_saw_dot, n_saw_dot;
    logic [ipc_pkg::V4_GC_W-1:0]         r_v4_gc, n_v4_gc;
    logic [ipc_pkg::V4_DC_W-1:0]         r_v4_dc, n_v4_dc;
    logic [ipc_pkg::V4_VAL_W-1:0]        r_v4_val, n_v4_val;
    logic                                r_v4_lz, n_v4_lz;
    logic                                r_v4_bad, n_v4_bad;
    logic [ipc_pkg::V6_GC_W-1:0]         r_v6_gc, n_v6_gc;
    logic [ipc_pkg::V6_DC_W-1:0]         r_v6_dc, n_v6_dc;
    logic                                r_v6_bad, n_v6_bad;

    logic                                r_out_valid;
    ipc_pkg::t_verdict                   r_verdict, n_verdict;

    logic                                out_free;
    logic                                s1_fire;
    logic                                in_fire;
    logic                                is_dot, is_colon, is_dec, is_hex;
    logic [3:0]                          digit;
    logic [ipc_pkg::V4_PROD_W-1:0]       prod;
    logic                                ok4, ok6;

    assign out_free       = !r_out_valid || o_verdict.ready;
    assign s1_fire        = r_in_valid && (!r_last || out_free);
    assign i_char.ready   = !r_in_valid || s1_fire;
    assign in_fire        = i_char.valid && i_char.ready;

    assign o_verdict.valid   = r_out_valid;
    assign o_verdict.verdict = r_verdict;

    // character classes
    assign is_dot   = (r_char == ipc_pkg::CHAR_DOT);
    assign is_colon = (r_char == ipc_pkg::CHAR_COLON);
    assign is_dec   = (r_char >= ipc_pkg::CHAR_0) && (r_char <= ipc_pkg::CHAR_9);
    assign is_hex   = is_dec
                   || ((r_char >= ipc_pkg::CHAR_LO_A) && (r_char <= ipc_pkg::CHAR_LO_F))
                   || ((r_char >= ipc_pkg::CHAR_UP_A) && (r_char <= ipc_pkg::CHAR_UP_F));
    assign digit    = r_char[3:0];
    assign prod     = ({3'b000, r_v4_val} * ipc_pkg::V4_RADIX) + {8'd0, digit};

    always_comb begin
        n_saw_dot = r_saw_dot || is_dot;

        n_v4_gc  = r_v4_gc;
        n_v4_dc  = r_v4_dc;
        n_v4_val = r_v4_val;
        n_v4_lz  = r_v4_lz;
        n_v4_bad = r_v4_bad;
        priority if (is_dot) begin
            if ((r_v4_dc == '0) || (r_v4_val > ipc_pkg::V4_VALUE_MAX)) begin
                n_v4_bad = 1'b1;
            end
            if (r_v4_gc >= ipc_pkg::V4_GROUPS_MAX) begin
                n_v4_bad = 1'b1;
            end else begin
                n_v4_gc = r_v4_gc + 1'b1;
            end
            n_v4_dc  = '0;
            n_v4_val = '0;
            n_v4_lz  = 1'b0;
        end else if (is_dec) begin
            if (r_v4_dc >= ipc_pkg::V4_DIGITS_MAX) begin
                n_v4_bad = 1'b1;
            end else begin
                if (r_v4_dc == '0) begin
                    n_v4_lz = (digit == 4'd0);
                end else if (r_v4_lz) begin
                    n_v4_bad = 1'b1;
                end
                n_v4_dc = r_v4_dc + 1'b1;
            end
            n_v4_val = (prod > ipc_pkg::V4_VALUE_SAT) ? ipc_pkg::V4_VALUE_SAT[ipc_pkg::V4_VAL_W-1:0]
                                                       : prod[ipc_pkg::V4_VAL_W-1:0];
        end else begin
            n_v4_bad = 1'b1;
        end

        n_v6_gc  = r_v6_gc;
        n_v6_dc  = r_v6_dc;
        n_v6_bad = r_v6_bad;
        priority if (is_colon) begin
            if (r_v6_dc == '0) begin
                n_v6_bad = 1'b1;
            end
            if (r_v6_gc >= ipc_pkg::V6_GROUPS_MAX) begin
                n_v6_bad = 1'b1;
            end else begin
                n_v6_gc = r_v6_gc + 1'b1;
            end
            n_v6_dc = '0;
        end else if (is_hex) begin
            if (r_v6_dc >= ipc_pkg::V6_DIGITS_MAX) begin
                n_v6_bad = 1'b1;
            end else begin
                n_v6_dc = r_v6_dc + 1'b1;
            end
        end else begin
            n_v6_bad = 1'b1;
        end

        // final group check on the updated state
        ok4 = !n_v4_bad && (n_v4_dc != '0) && (n_v4_val <= ipc_pkg::V4_VALUE_MAX)
           && (n_v4_gc == ipc_pkg::V4_GROUPS_MAX);
        ok6 = !n_v6_bad && (n_v6_dc != '0) && (n_v6_gc == ipc_pkg::V6_GROUPS_MAX);
        if (n_saw_dot) begin
            n_verdict = ok4 ? ipc_pkg::VERDICT_V4 : ipc_pkg::VERDICT_NONE;
        end else begin
            n_verdict = ok6 ? ipc_pkg::VERDICT_V6 : ipc_pkg::VERDICT_NONE;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
        if (in_fire) begin
            r_char <= i_char.character;
            r_last <= i_char.last_char;
        end
    end

    // per-string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_fire && r_last)) begin
            r_saw_dot <= 1'b0;
            r_v4_gc   <= '0;
            r_v4_dc   <= '0;
            r_v4_val  <= '0;
            r_v4_lz   <= 1'b0;
            r_v4_bad  <= 1'b0;
            r_v6_gc   <= '0;
            r_v6_dc   <= '0;
            r_v6_bad  <= 1'b0;
        end else if (s1_fire) begin
            r_saw_dot <= n_saw_dot;
            r_v4_gc   <= n_v4_gc;
            r_v4_dc   <= n_v4_dc;
            r_v4_val  <= n_v4_val;
            r_v4_lz   <= n_v4_lz;
            r_v4_bad  <= n_v4_bad;
            r_v6_gc   <= n_v6_gc;
            r_v6_dc   <= n_v6_dc;
            r_v6_bad  <= n_v6_bad;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_fire && r_last) begin
            r_verdict <= n_verdict;
        end
    end

    `ASSERT_IMPL(a_v4_gc_limit, i_clk, i_rst_n, r_in_valid || !r_in_valid,
        (r_v4_gc <= ipc_pkg::V4_GROUPS_MAX) && (r_v6_gc <= ipc_pkg::V6_GROUPS_MAX),
        "group count beyond its limit")
    `ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, s1_fire && r_last,
        !r_saw_dot && (r_v4_gc == '0) && (r_v6_gc == '0) && !r_v4_bad && !r_v6_bad,
        "string state not cleared after the final character")
    `ASSERT_NEXT(a_verdict_loaded, i_clk, i_rst_n, s1_fire && r_last, r_out_valid,
        "final character gave no verdict item")
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_verdict.ready,
        !(s1_fire && r_last), "pending verdict item overwritten")

endmodule
